### design/lmrsd_pkg.sv
package lmrsd_pkg;

   localparam int SHIFT_BITS = 16;
   localparam int COUNT_W    = 4;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_SET   = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef enum logic {
      ST_IDLE  = 1'b0,
      ST_SHIFT = 1'b1
   } state_type;

endpackage

### design/led_matrix_row_scan_driver_core.sv
// LED matrix row-scan driver for a SIZE x SIZE matrix behind two 16-bit shift chains.
// The request channel carries one command per transaction: a scan tick, a
// pixel set or a clear of the whole pixel store. A set writes one pixel with
// its coordinates mirrored and swapped; a set outside the matrix is dropped.
// Set and clear produce no response.
// A scan tick produces sixteen response transactions, bit 15 first, each
// carrying one bit for the row chain (active low) and one for the column
// chain; the last carries the latch flag. Accepting the tick loads the two
// 16-bit shift registers; the first bit is offered in the cycle after the
// tick is accepted and each further bit in the cycle after the previous
// one is taken. The next request is accepted in the cycle after the latch
// bit is taken. While the receiver stalls, the shift registers hold and
// requests are not accepted. Reset clears the pixel store, sets the scan
// row to zero and leaves the block idle with no response pending.
module led_matrix_row_scan_driver_core #(
   parameter int SIZE = 10
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_opcode,
   input  logic [3:0] req_pixel_row,
   input  logic [3:0] req_pixel_col,
   input  logic       req_pixel_on,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_row_select_bit,
   output logic       rsp_column_bit,
   output logic       rsp_latch
);

   localparam int ROW_W = (SIZE > 1) ? $clog2(SIZE) : 1;
   localparam int SB    = lmrsd_pkg::SHIFT_BITS;

   lmrsd_pkg::state_type state_ff, state_in;

   logic [SIZE-1:0]                  store_ff [SIZE];
   logic [SIZE-1:0]                  store_in [SIZE];
   logic [ROW_W-1:0]                 active_row_ff, active_row_in;
   logic [SB-1:0]                    row_shift_ff, row_shift_in;
   logic [SB-1:0]                    col_shift_ff, col_shift_in;
   logic [lmrsd_pkg::COUNT_W-1:0]    count_ff, count_in;

   logic             req_fire, rsp_fire;
   logic             is_tick, is_set, is_clear;
   logic             in_range;
   logic [ROW_W-1:0] set_row, set_col;
   logic [SB-1:0]    row_word, col_word;
   logic             last_bit;

   assign req_fire = req_valid && req_ready;
   assign rsp_fire = rsp_valid && rsp_ready;
   assign last_bit = (count_ff == lmrsd_pkg::COUNT_W'(SB - 1));

   always_comb begin
      is_tick  = 1'b0;
      is_set   = 1'b0;
      is_clear = 1'b0;
      case (lmrsd_pkg::opcode_type'(req_opcode))
         lmrsd_pkg::OP_TICK:  is_tick  = 1'b1;
         lmrsd_pkg::OP_SET:   is_set   = 1'b1;
         lmrsd_pkg::OP_CLEAR: is_clear = 1'b1;
         default: begin
         end
      endcase
   end

   assign in_range = (5'(req_pixel_row) < 5'(SIZE)) && (5'(req_pixel_col) < 5'(SIZE));
   assign set_row  = ROW_W'(5'(SIZE - 1) - 5'(req_pixel_col));
   assign set_col  = ROW_W'(5'(SIZE - 1) - 5'(req_pixel_row));

   always_comb begin
      for (int r = 0; r < SIZE; r++) begin
         store_in[r] = store_ff[r];
         if (req_fire && is_clear) begin
            store_in[r] = '0;
         end else if (req_fire && is_set && in_range && (set_row == ROW_W'(r))) begin
            store_in[r][set_col] = req_pixel_on;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < SB; i++) begin
         if (i < SIZE) begin
            row_word[i] = (active_row_ff != ROW_W'(i));
            col_word[i] = store_ff[active_row_ff][ROW_W'(i)];
         end else begin
            row_word[i] = 1'b0;
            col_word[i] = 1'b0;
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lmrsd_pkg::ST_IDLE: begin
            if (req_fire && is_tick) begin
               state_in = lmrsd_pkg::ST_SHIFT;
            end
         end
         lmrsd_pkg::ST_SHIFT: begin
            if (rsp_fire && last_bit) begin
               state_in = lmrsd_pkg::ST_IDLE;
            end
         end
         default: state_in = lmrsd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         lmrsd_pkg::ST_IDLE:  req_ready = 1'b1;
         lmrsd_pkg::ST_SHIFT: rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   always_comb begin
      row_shift_in  = row_shift_ff;
      col_shift_in  = col_shift_ff;
      count_in      = count_ff;
      active_row_in = active_row_ff;
      if (req_fire && is_tick) begin
         row_shift_in = row_word;
         col_shift_in = col_word;
         count_in     = '0;
         if (active_row_ff == ROW_W'(SIZE - 1)) begin
            active_row_in = '0;
         end else begin
            active_row_in = active_row_ff + ROW_W'(1);
         end
      end else if (rsp_fire) begin
         row_shift_in = {row_shift_ff[SB-2:0], 1'b0};
         col_shift_in = {col_shift_ff[SB-2:0], 1'b0};
         count_in     = count_ff + lmrsd_pkg::COUNT_W'(1);
      end
   end

   assign rsp_row_select_bit = row_shift_ff[SB-1];
   assign rsp_column_bit     = col_shift_ff[SB-1];
   assign rsp_latch          = last_bit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= lmrsd_pkg::ST_IDLE;
         active_row_ff <= '0;
         count_ff      <= '0;
         for (int r = 0; r < SIZE; r++) begin
            store_ff[r] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         active_row_ff <= active_row_in;
         count_ff      <= count_in;
         for (int r = 0; r < SIZE; r++) begin
            store_ff[r] <= store_in[r];
         end
      end
   end

   always_ff @(posedge clock) begin
      row_shift_ff <= row_shift_in;
      col_shift_ff <= col_shift_in;
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while a scan is being shifted out");

   a_tick_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_tick) |=> (rsp_valid && (count_ff == '0)))
      else $error("scan tick did not start the shift sequence");

   a_latch_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_latch) |=> !rsp_valid)
      else $error("response continued after the latch bit");

   a_row_range: assert property (@(posedge clock) disable iff (reset)
      5'(active_row_ff) < 5'(SIZE))
      else $error("scan row left the matrix");

endmodule
